>>> rtl/cco_pkg.sv
// Shared types, constants and the rounded divide-by-255 helper for the coverage blender.
`default_nettype none

package cco_pkg;

	localparam int ChW    = 8;
	localparam int ProdW  = 2 * ChW;
	localparam int ColorW = 32;
	localparam int PosW   = 14;
	localparam int DimW   = 13;
	localparam int CfgIdxW = 1;

	localparam logic [CfgIdxW-1:0] CFG_FRAME_COLS = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_FRAME_ROWS = 1'b1;

	localparam logic [ChW-1:0]   FullScale = 8'hFF;
	localparam logic [ProdW:0]   RndHalf   = 17'd128;
	localparam logic [ProdW:0]   RndOne    = 17'd1;

	typedef struct packed {
		logic [ChW-1:0] red;
		logic [ChW-1:0] green;
		logic [ChW-1:0] blue;
		logic [ChW-1:0] alpha;
	} rgba_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	// Exact (p + 128) / 255 for any product of two bytes.
	function automatic logic [ChW-1:0] div255_round(input logic [ProdW-1:0] p);
		logic [ProdW:0] t;
		logic [ProdW:0] q;
		t = {1'b0, p} + RndHalf;
		q = (t + (t >> ChW) + RndOne) >> ChW;
		return q[ChW-1:0];
	endfunction

endpackage

`default_nettype wire

>>> rtl/coverage_color_over_blend.sv
// Top level of the coverage-weighted source-over pixel blender.
`default_nettype none

// Blends one subtitle color over one destination RGBA pixel per clock. Each input
// word carries a glyph coverage byte, a packed color whose top byte is inverted
// alpha, the destination pixel and its frame position. Source alpha is coverage
// times color alpha divided by 255 with rounding; color channels are premultiplied
// the same way, destination channels are scaled by the inverse alpha and the 8-bit
// sums wrap. Pixels outside the frame, or with a zero source alpha, come out
// unchanged with write_pixel low. The datapath is four register stages deep:
// clip and alpha product, alpha rounding, the seven channel multipliers, then
// rounding, sum and select. A word passes through these in order on its way to
// the output, and a new word can be accepted on every clock unless the output
// stalls. Each stage advances when it is empty or when the stage after it
// advances, so a stall at the output backs up only as far as needed and
// in_ready falls only when all four stages hold words. The user must write frame
// width and height through the cfg port only while the pipeline is empty; the
// block itself does not enforce this. A size of zero clips every pixel.
module coverage_color_over_blend (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [cco_pkg::CfgIdxW-1:0]      cfg_index,
	input  wire logic [cco_pkg::DimW-1:0]         cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [cco_pkg::ChW-1:0]          coverage,
	input  wire logic [cco_pkg::ColorW-1:0]       packed_color,
	input  wire logic signed [cco_pkg::PosW-1:0]  pos_x,
	input  wire logic signed [cco_pkg::PosW-1:0]  pos_y,
	input  wire logic [cco_pkg::ChW-1:0]          dest_red,
	input  wire logic [cco_pkg::ChW-1:0]          dest_green,
	input  wire logic [cco_pkg::ChW-1:0]          dest_blue,
	input  wire logic [cco_pkg::ChW-1:0]          dest_alpha,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [cco_pkg::ChW-1:0]               out_red,
	output logic [cco_pkg::ChW-1:0]               out_green,
	output logic [cco_pkg::ChW-1:0]               out_blue,
	output logic [cco_pkg::ChW-1:0]               out_alpha,
	output logic                                  write_pixel
);

	logic [cco_pkg::DimW-1:0] frame_cols_q;
	logic [cco_pkg::DimW-1:0] frame_rows_q;

	// Valid bits that travel alongside each stage's data.
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	cco_pkg::stage_en_t adv;

	cco_pkg::rgba_t         dest;
	logic [cco_pkg::ChW-1:0] sa_s2;
	logic [cco_pkg::ChW-1:0] inv_s2;
	logic                   draw_s2;
	cco_pkg::rgba_t         src_s2;
	cco_pkg::rgba_t         dest_s2;
	cco_pkg::rgba_t         pix_s4;
	logic                   write_s4;

	// Frame size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_cols_q <= '0;
			frame_rows_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				cco_pkg::CFG_FRAME_COLS: frame_cols_q <= cfg_data;
				cco_pkg::CFG_FRAME_ROWS: frame_rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A stage loads when it is empty or its current word moves on.
	always_comb begin
		adv.s4 = !vld_s4 || out_ready;
		adv.s3 = !vld_s3 || adv.s4;
		adv.s2 = !vld_s2 || adv.s3;
		adv.s1 = !vld_s1 || adv.s2;
	end

	assign in_ready = adv.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (adv.s1) begin
				vld_s1 <= in_valid;
			end
			if (adv.s2) begin
				vld_s2 <= vld_s1;
			end
			if (adv.s3) begin
				vld_s3 <= vld_s2;
			end
			if (adv.s4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	always_comb begin
		dest.red   = dest_red;
		dest.green = dest_green;
		dest.blue  = dest_blue;
		dest.alpha = dest_alpha;
	end

	cco_alpha u_alpha (
		.clk          (clk),
		.en           (adv),
		.coverage     (coverage),
		.packed_color (packed_color),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.dest         (dest),
		.frame_cols   (frame_cols_q),
		.frame_rows   (frame_rows_q),
		.sa_s2        (sa_s2),
		.inv_s2       (inv_s2),
		.draw_s2      (draw_s2),
		.src_s2       (src_s2),
		.dest_s2      (dest_s2)
	);

	cco_blend u_blend (
		.clk      (clk),
		.en       (adv),
		.sa_s2    (sa_s2),
		.inv_s2   (inv_s2),
		.draw_s2  (draw_s2),
		.src_s2   (src_s2),
		.dest_s2  (dest_s2),
		.pix_s4   (pix_s4),
		.write_s4 (write_s4)
	);

	assign out_valid   = vld_s4;
	assign out_red     = pix_s4.red;
	assign out_green   = pix_s4.green;
	assign out_blue    = pix_s4.blue;
	assign out_alpha   = pix_s4.alpha;
	assign write_pixel = write_s4;

	// The input only stalls when every stage is occupied.
	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4))
		else $error("input stalled with an empty stage");

	// An accepted word lands in stage one.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_s1)
		else $error("accepted word lost at stage one");

	// A word held in the middle of the pipe is not dropped.
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !adv.s3) |=> vld_s2)
		else $error("stalled word dropped at stage two");

	// A word leaving stage three always reaches the output stage.
	a_s3_to_s4: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && adv.s4) |=> vld_s4)
		else $error("word lost between stages three and four");

endmodule

`default_nettype wire

>>> rtl/cco_alpha.sv
// Stages one and two: frame clipping, coverage times color alpha, source alpha rounding.
`default_nettype none

module cco_alpha (
	input  wire logic                         clk,
	input  wire cco_pkg::stage_en_t           en,
	input  wire logic [cco_pkg::ChW-1:0]      coverage,
	input  wire logic [cco_pkg::ColorW-1:0]   packed_color,
	input  wire logic signed [cco_pkg::PosW-1:0] pos_x,
	input  wire logic signed [cco_pkg::PosW-1:0] pos_y,
	input  wire cco_pkg::rgba_t               dest,
	input  wire logic [cco_pkg::DimW-1:0]     frame_cols,
	input  wire logic [cco_pkg::DimW-1:0]     frame_rows,
	output logic [cco_pkg::ChW-1:0]           sa_s2,
	output logic [cco_pkg::ChW-1:0]           inv_s2,
	output logic                              draw_s2,
	output cco_pkg::rgba_t                    src_s2,
	output cco_pkg::rgba_t                    dest_s2
);

	logic                           in_frame;
	logic [cco_pkg::ChW-1:0]        color_alpha;
	logic [cco_pkg::ProdW-1:0]      prod_s1;
	logic                           in_frame_s1;
	cco_pkg::rgba_t                 src_s1;
	cco_pkg::rgba_t                 dest_s1;
	logic [cco_pkg::ChW-1:0]        sa;

	// Sign bit clear means the coordinate is not negative.
	assign in_frame = !pos_x[cco_pkg::PosW-1] && !pos_y[cco_pkg::PosW-1] &&
		(pos_x[cco_pkg::DimW-1:0] < frame_cols) &&
		(pos_y[cco_pkg::DimW-1:0] < frame_rows);

	assign color_alpha = cco_pkg::FullScale - packed_color[31:24];

	always_ff @(posedge clk) begin
		if (en.s1) begin
			prod_s1      <= coverage * color_alpha;
			in_frame_s1  <= in_frame;
			src_s1.red   <= packed_color[7:0];
			src_s1.green <= packed_color[15:8];
			src_s1.blue  <= packed_color[23:16];
			src_s1.alpha <= '0;
			dest_s1      <= dest;
		end
	end

	// A zero coverage or zero color alpha gives a zero product and so a zero source alpha.
	assign sa = cco_pkg::div255_round(prod_s1);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			sa_s2   <= sa;
			inv_s2  <= cco_pkg::FullScale - sa;
			draw_s2 <= in_frame_s1 && (sa != '0);
			src_s2  <= src_s1;
			dest_s2 <= dest_s1;
		end
	end

endmodule

`default_nettype wire

>>> rtl/cco_blend.sv
// Stages three and four: channel products, rounding, wrapped sums and pass-through select.
`default_nettype none

module cco_blend (
	input  wire logic                    clk,
	input  wire cco_pkg::stage_en_t      en,
	input  wire logic [cco_pkg::ChW-1:0] sa_s2,
	input  wire logic [cco_pkg::ChW-1:0] inv_s2,
	input  wire logic                    draw_s2,
	input  wire cco_pkg::rgba_t          src_s2,
	input  wire cco_pkg::rgba_t          dest_s2,
	output cco_pkg::rgba_t               pix_s4,
	output logic                         write_s4
);

	logic [cco_pkg::ProdW-1:0] sr_s3, sg_s3, sb_s3;
	logic [cco_pkg::ProdW-1:0] dr_s3, dg_s3, db_s3, da_s3;
	logic [cco_pkg::ChW-1:0]   sa_s3;
	logic                      draw_s3;
	cco_pkg::rgba_t            dest_s3;
	cco_pkg::rgba_t            blend;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			sr_s3   <= src_s2.red   * sa_s2;
			sg_s3   <= src_s2.green * sa_s2;
			sb_s3   <= src_s2.blue  * sa_s2;
			dr_s3   <= dest_s2.red   * inv_s2;
			dg_s3   <= dest_s2.green * inv_s2;
			db_s3   <= dest_s2.blue  * inv_s2;
			da_s3   <= dest_s2.alpha * inv_s2;
			sa_s3   <= sa_s2;
			draw_s3 <= draw_s2;
			dest_s3 <= dest_s2;
		end
	end

	// Eight-bit sums wrap on overflow.
	always_comb begin
		blend.red   = cco_pkg::div255_round(sr_s3) + cco_pkg::div255_round(dr_s3);
		blend.green = cco_pkg::div255_round(sg_s3) + cco_pkg::div255_round(dg_s3);
		blend.blue  = cco_pkg::div255_round(sb_s3) + cco_pkg::div255_round(db_s3);
		blend.alpha = sa_s3 + cco_pkg::div255_round(da_s3);
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			pix_s4   <= draw_s3 ? blend : dest_s3;
			write_s4 <= draw_s3;
		end
	end

endmodule

`default_nettype wire

>>> tb/tb_coverage_color_over_blend.sv
// Self-checking testbench for the coverage-weighted source-over pixel blender.
`default_nettype none

module tb_coverage_color_over_blend;

	// The longest output hold-off is counted in the receiver's own process. The stall
	// limit only has to cover it plus the worst random gaps and the pipeline depth.
	localparam int RxHoldCycles = 200;
	localparam int StallLimit   = 3000;
	localparam int MaxReports   = 10;
	localparam int TailCycles   = 8;

	// One blended pixel as it leaves the block.
	typedef struct packed {
		logic [cco_pkg::ChW-1:0] red;
		logic [cco_pkg::ChW-1:0] green;
		logic [cco_pkg::ChW-1:0] blue;
		logic [cco_pkg::ChW-1:0] alpha;
		logic                    write;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                            cfg_wr_en = 1'b0;
	logic [cco_pkg::CfgIdxW-1:0]     cfg_index = '0;
	logic [cco_pkg::DimW-1:0]        cfg_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [cco_pkg::ChW-1:0]         coverage = '0;
	logic [cco_pkg::ColorW-1:0]      packed_color = '0;
	logic signed [cco_pkg::PosW-1:0] pos_x = '0;
	logic signed [cco_pkg::PosW-1:0] pos_y = '0;
	logic [cco_pkg::ChW-1:0]         dest_red = '0;
	logic [cco_pkg::ChW-1:0]         dest_green = '0;
	logic [cco_pkg::ChW-1:0]         dest_blue = '0;
	logic [cco_pkg::ChW-1:0]         dest_alpha = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [cco_pkg::ChW-1:0]         out_red;
	logic [cco_pkg::ChW-1:0]         out_green;
	logic [cco_pkg::ChW-1:0]         out_blue;
	logic [cco_pkg::ChW-1:0]         out_alpha;
	logic                            write_pixel;

	// Frame size as the block should currently see it, updated from the cfg port.
	logic [cco_pkg::DimW-1:0] frame_w = '0;
	logic [cco_pkg::DimW-1:0] frame_h = '0;

	pixel_t expected_pixels[$];
	int     mismatches = 0;

	// Idling controls shared between the test tasks and the two handshake sides.
	bit tx_no_gaps = 1'b0;
	bit rx_no_gaps = 1'b0;
	bit rx_hold_req = 1'b0;

	coverage_color_over_blend uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.coverage     (coverage),
		.packed_color (packed_color),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.dest_red     (dest_red),
		.dest_green   (dest_green),
		.dest_blue    (dest_blue),
		.dest_alpha   (dest_alpha),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.out_alpha    (out_alpha),
		.write_pixel  (write_pixel)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Rounded product of two bytes over 255, done with a plain integer divide.
	function automatic logic [cco_pkg::ChW-1:0] scale255(input logic [cco_pkg::ChW-1:0] v,
			input logic [cco_pkg::ChW-1:0] s);
		int unsigned p;
		p = int'(v) * int'(s) + 128;
		return cco_pkg::ChW'(p / 255);
	endfunction

	// Expected result of one word under the current frame size. The pixel is passed
	// through untouched unless it lies inside the frame and has a nonzero rounded alpha.
	function automatic pixel_t blend_pixel(input logic [cco_pkg::ChW-1:0] cov,
			input logic [cco_pkg::ColorW-1:0] color,
			input logic signed [cco_pkg::PosW-1:0] px,
			input logic signed [cco_pkg::PosW-1:0] py, input logic [cco_pkg::ChW-1:0] dr,
			input logic [cco_pkg::ChW-1:0] dg, input logic [cco_pkg::ChW-1:0] db,
			input logic [cco_pkg::ChW-1:0] da);
		pixel_t res;
		int x;
		int y;
		logic [cco_pkg::ChW-1:0] base_a;
		logic [cco_pkg::ChW-1:0] src_a;
		logic [cco_pkg::ChW-1:0] inv_a;
		x = px;
		y = py;
		res.red = dr;
		res.green = dg;
		res.blue = db;
		res.alpha = da;
		res.write = 1'b0;
		if (x < 0 || y < 0 || x >= int'(frame_w) || y >= int'(frame_h))
			return res;
		base_a = 8'hFF - color[31:24];
		if (base_a == 0 || cov == 0)
			return res;
		src_a = scale255(cov, base_a);
		if (src_a == 0)
			return res;
		inv_a = 8'hFF - src_a;
		// The channel sums are truncated to eight bits by the assignments.
		res.red = scale255(color[7:0], src_a) + scale255(dr, inv_a);
		res.green = scale255(color[15:8], src_a) + scale255(dg, inv_a);
		res.blue = scale255(color[23:16], src_a) + scale255(db, inv_a);
		res.alpha = src_a + scale255(da, inv_a);
		res.write = 1'b1;
		return res;
	endfunction

	// Scoreboard. Everything is sampled at the rising edge, where the values seen are
	// the ones driven at the previous falling edge. Register writes update the local
	// frame size, accepted input words queue their prediction, and each accepted
	// output word is checked against the oldest prediction.
	always @(posedge clk) begin
		pixel_t want;
		pixel_t got;
		if (arst_n) begin
			if (cfg_wr_en) begin
				case (cfg_index)
					cco_pkg::CFG_FRAME_COLS: begin
						frame_w = cfg_data;
					end
					cco_pkg::CFG_FRAME_ROWS: begin
						frame_h = cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (in_valid && in_ready)
				expected_pixels = {expected_pixels, blend_pixel(coverage, packed_color,
					pos_x, pos_y, dest_red, dest_green, dest_blue, dest_alpha)};
			if (out_valid && out_ready) begin
				got = '{out_red, out_green, out_blue, out_alpha, write_pixel};
				if (expected_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= MaxReports)
						$display("unexpected word: r=%0d g=%0d b=%0d a=%0d wr=%0b",
							got.red, got.green, got.blue, got.alpha, got.write);
				end else begin
					want = expected_pixels.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= MaxReports) begin
							$write("mismatch: expected r=%0d g=%0d b=%0d a=%0d wr=%0b, ",
								want.red, want.green, want.blue, want.alpha, want.write);
							$display("got r=%0d g=%0d b=%0d a=%0d wr=%0b",
								got.red, got.green, got.blue, got.alpha, got.write);
						end
					end
				end
			end
		end
	end

	// Watchdog: the run is declared hung after too many cycles with no handshake at all.
	initial begin
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < StallLimit) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en || !arst_n)
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	// Receiver. Before each word it idles for a random number of cycles, or for a long
	// stretch when a test asks for it, then holds ready high until a word is taken.
	initial begin
		int gap;
		forever begin
			gap = rx_no_gaps ? 0 : int'($urandom_range(0, 18));
			@(negedge clk);
			if (rx_hold_req) begin
				out_ready <= 1'b0;
				repeat (RxHoldCycles) @(negedge clk);
				rx_hold_req = 1'b0;
			end else if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Sends one word: an optional random gap with valid low, then the payload with valid
	// high until the block takes it. Returns at the accepting rising edge, so valid is
	// never lowered and raised in the same step when words follow back to back.
	task automatic send_pixel(input logic [cco_pkg::ChW-1:0] cov,
			input logic [cco_pkg::ColorW-1:0] color, input int x, input int y,
			input logic [cco_pkg::ChW-1:0] dr, input logic [cco_pkg::ChW-1:0] dg,
			input logic [cco_pkg::ChW-1:0] db, input logic [cco_pkg::ChW-1:0] da);
		int gap;
		gap = tx_no_gaps ? 0 : int'($urandom_range(0, 18));
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		coverage <= cov;
		packed_color <= color;
		pos_x <= x[cco_pkg::PosW-1:0];
		pos_y <= y[cco_pkg::PosW-1:0];
		dest_red <= dr;
		dest_green <= dg;
		dest_blue <= db;
		dest_alpha <= da;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// Directed word with a random destination pixel.
	task automatic send_over_random_dest(input logic [cco_pkg::ChW-1:0] cov,
			input logic [cco_pkg::ColorW-1:0] color, input int x, input int y);
		send_pixel(cov, color, x, y, cco_pkg::ChW'($urandom), cco_pkg::ChW'($urandom),
			cco_pkg::ChW'($urandom), cco_pkg::ChW'($urandom));
	endtask

	// Stops offering words and waits until every predicted word has come out.
	task automatic drain_pipeline();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (expected_pixels.size() == 0);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [cco_pkg::CfgIdxW-1:0] idx,
			input logic [cco_pkg::DimW-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Frame size changes only with the pipeline empty.
	task automatic set_frame(input int w, input int h);
		drain_pipeline();
		write_reg(cco_pkg::CFG_FRAME_COLS, w[cco_pkg::DimW-1:0]);
		write_reg(cco_pkg::CFG_FRAME_ROWS, h[cco_pkg::DimW-1:0]);
	endtask

	// Position along one axis: mostly around the frame, with some negative values and
	// some fully random ones so that every bit of the field toggles.
	function automatic int pick_pos(input int limit);
		case ($urandom_range(0, 9))
			0: return int'($urandom_range(0, 16383));
			1: return int'($urandom_range(0, 7)) - 8;
			default: return int'($urandom_range(0, limit + 2));
		endcase
	endfunction

	task automatic send_random_pixel();
		logic [cco_pkg::ChW-1:0] cov;
		logic [cco_pkg::ChW-1:0] inv_byte;
		logic [cco_pkg::ColorW-1:0] color;
		case ($urandom_range(0, 7))
			0: cov = 8'd0;
			1: cov = 8'hFF;
			2: cov = cco_pkg::ChW'($urandom_range(1, 3));
			default: cov = cco_pkg::ChW'($urandom);
		endcase
		case ($urandom_range(0, 7))
			0: inv_byte = 8'd0;
			1: inv_byte = 8'hFF;
			2: inv_byte = 8'hFE;
			default: inv_byte = cco_pkg::ChW'($urandom);
		endcase
		color = {inv_byte, 24'($urandom)};
		send_over_random_dest(cov, color, pick_pos(int'(frame_w)), pick_pos(int'(frame_h)));
	endtask

	// After reset both sizes are zero, so even a fully opaque word must pass through.
	task automatic test_reset_clips_all();
		send_over_random_dest(8'hFF, 32'h00FF_FFFF, 0, 0);
		send_over_random_dest(8'hFF, 32'h0012_3456, 5, 5);
	endtask

	// Alpha corner cases and the sign and boundary cases of the clip test.
	task automatic test_directed_cases();
		set_frame(8191, 8191);
		send_over_random_dest(8'd0, 32'h0080_4020, 10, 10);     // no coverage
		send_over_random_dest(8'hFF, 32'h0080_4020, 10, 10);    // fully opaque source
		send_over_random_dest(8'hFF, 32'hFF80_4020, 10, 10);    // color alpha of zero
		send_over_random_dest(8'd1, 32'hFE80_4020, 10, 10);     // source alpha rounds to zero
		send_pixel(8'd128, 32'h00FF_FFFF, 3, 3, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'hFF, 32'hFFFF_FFFF, 3, 3, 8'd0, 8'd0, 8'd0, 8'd0);
		send_pixel(8'hFF, 32'h00FF_FFFF, 3, 3, 8'd0, 8'd0, 8'd0, 8'd0);
		send_pixel(8'hFF, 32'h0000_0000, 3, 3, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_over_random_dest(8'hFF, 32'h0011_2233, -1, 0);
		send_over_random_dest(8'hFF, 32'h0011_2233, 0, -1);
		send_over_random_dest(8'hFF, 32'h0011_2233, -8192, -8192);
		send_over_random_dest(8'hFF, 32'h0011_2233, 8191, 8191);
		send_over_random_dest(8'hFF, 32'h0011_2233, 8190, 8190);
		// Right and bottom edges of a small frame.
		set_frame(100, 50);
		send_over_random_dest(8'hC0, 32'h4011_2233, 99, 49);
		send_over_random_dest(8'hC0, 32'h4011_2233, 100, 0);
		send_over_random_dest(8'hC0, 32'h4011_2233, 0, 50);
		send_over_random_dest(8'hC0, 32'h4011_2233, 0, 0);
		// Smallest frame that holds a pixel.
		set_frame(1, 1);
		send_over_random_dest(8'h7F, 32'h2099_AA55, 0, 0);
		send_over_random_dest(8'h7F, 32'h2099_AA55, 1, 0);
		send_over_random_dest(8'h7F, 32'h2099_AA55, 0, 1);
	endtask

	// Random words over a run of frame sizes. The idling pattern changes every 50 words,
	// so there are stretches where one side, both or neither side pauses.
	task automatic test_random_frames();
		int sizes[8][2];
		sizes = '{'{640, 480}, '{1, 8191}, '{8191, 1}, '{0, 300},
			'{8191, 8191}, '{37, 23}, '{300, 0}, '{64, 64}};
		foreach (sizes[i]) begin
			set_frame(sizes[i][0], sizes[i][1]);
			for (int n = 0; n < 160; n++) begin
				if (n % 50 == 0) begin
					tx_no_gaps = 1'($urandom_range(0, 1));
					rx_no_gaps = 1'($urandom_range(0, 1));
				end
				send_random_pixel();
			end
		end
		set_frame(int'($urandom_range(1, 200)), int'($urandom_range(1, 200)));
		for (int n = 0; n < 40; n++)
			send_random_pixel();
		tx_no_gaps = 1'b0;
		rx_no_gaps = 1'b0;
	endtask

	// The receiver holds off for a long stretch while words keep coming back to back,
	// so the pipeline fills and in_ready has to drop.
	task automatic test_output_backpressure();
		set_frame(256, 256);
		rx_hold_req = 1'b1;
		tx_no_gaps = 1'b1;
		for (int n = 0; n < 60; n++)
			send_random_pixel();
		tx_no_gaps = 1'b0;
	endtask

	// The sender waits until every word has come out, then resumes at full rate.
	task automatic test_burst_after_drain();
		for (int n = 0; n < 20; n++)
			send_random_pixel();
		drain_pipeline();
		tx_no_gaps = 1'b1;
		rx_no_gaps = 1'b1;
		for (int n = 0; n < 20; n++)
			send_random_pixel();
		tx_no_gaps = 1'b0;
		rx_no_gaps = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_clips_all();
		test_directed_cases();
		test_random_frames();
		test_output_backpressure();
		test_burst_after_drain();

		// Wait for the last words, then give the block a few more cycles to show any
		// extra output word it should not produce.
		drain_pipeline();
		repeat (TailCycles) @(posedge clk);
		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
